// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the byte stream hash block.
// Needs clk_i in the scope of every use, and rst_ni for BSSFH_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BSSFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define BSSFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/bssfh_pkg.sv =====
// Package of the byte stream hash block: word types, register map, ALU codes
// and the microcode ROM of the mixing sequencer. No dependencies.
`default_nettype none

package bssfh_pkg;

  typedef struct packed {
    logic        first_byte;
    logic [30:0] message_length;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest;
    logic        length_mismatch;
  } out_word_t;

  typedef struct packed {
    logic [30:0] table_size;
    logic        string_mode;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } seq_stat_t;

  // register index = paddr[2]
  localparam logic REG_IDX_TABLE_SIZE  = 1'b0;
  localparam logic REG_IDX_STRING_MODE = 1'b1;

  localparam logic [30:0] TABLE_SIZE_RST = 31'd1024;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_XOR = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_e;

  // operand B of a microcode step
  typedef enum logic [2:0] {
    SRC_SHL  = 3'd0,  // h << amt
    SRC_SHR  = 3'd1,  // h >> amt
    SRC_LO16 = 3'd2,  // low half of the word
    SRC_HI11 = 3'd3,  // high half of the word << 11
    SRC_B2   = 3'd4,  // widened byte 2 << 18
    SRC_B0   = 3'd5   // widened byte 0
  } src_e;

  typedef enum logic [1:0] {
    NXT_STEP     = 2'd0,
    NXT_MIX_END  = 2'd1,
    NXT_AVAL     = 2'd2,
    NXT_HASH_END = 2'd3
  } nxt_e;

  typedef struct packed {
    alu_op_e    op;
    src_e       src;
    logic [4:0] amt;
    nxt_e       nxt;
  } uop_t;

  localparam logic [4:0] PC_MIX   = 5'd0;
  localparam logic [4:0] PC_TAIL3 = 5'd4;
  localparam logic [4:0] PC_TAIL2 = 5'd8;
  localparam logic [4:0] PC_TAIL1 = 5'd11;
  localparam logic [4:0] PC_AVAL  = 5'd14;

  function automatic uop_t uop_rom(input logic [4:0] pc);
    uop_t u;
    case (pc)
      // word mix
      5'd0:  u = '{ALU_ADD, SRC_LO16, 5'd0,  NXT_STEP};
      5'd1:  u = '{ALU_XOR, SRC_SHL,  5'd16, NXT_STEP};
      5'd2:  u = '{ALU_XOR, SRC_HI11, 5'd0,  NXT_STEP};
      5'd3:  u = '{ALU_ADD, SRC_SHR,  5'd11, NXT_MIX_END};
      // three byte tail
      5'd4:  u = '{ALU_ADD, SRC_LO16, 5'd0,  NXT_STEP};
      5'd5:  u = '{ALU_XOR, SRC_SHL,  5'd16, NXT_STEP};
      5'd6:  u = '{ALU_XOR, SRC_B2,   5'd0,  NXT_STEP};
      5'd7:  u = '{ALU_ADD, SRC_SHR,  5'd11, NXT_AVAL};
      // two byte tail
      5'd8:  u = '{ALU_ADD, SRC_LO16, 5'd0,  NXT_STEP};
      5'd9:  u = '{ALU_XOR, SRC_SHL,  5'd11, NXT_STEP};
      5'd10: u = '{ALU_ADD, SRC_SHR,  5'd17, NXT_AVAL};
      // one byte tail
      5'd11: u = '{ALU_ADD, SRC_B0,   5'd0,  NXT_STEP};
      5'd12: u = '{ALU_XOR, SRC_SHL,  5'd10, NXT_STEP};
      5'd13: u = '{ALU_ADD, SRC_SHR,  5'd1,  NXT_AVAL};
      // avalanche
      5'd14: u = '{ALU_XOR, SRC_SHL,  5'd3,  NXT_STEP};
      5'd15: u = '{ALU_ADD, SRC_SHR,  5'd5,  NXT_STEP};
      5'd16: u = '{ALU_XOR, SRC_SHL,  5'd4,  NXT_STEP};
      5'd17: u = '{ALU_ADD, SRC_SHR,  5'd17, NXT_STEP};
      5'd18: u = '{ALU_XOR, SRC_SHL,  5'd25, NXT_STEP};
      5'd19: u = '{ALU_ADD, SRC_SHR,  5'd6,  NXT_HASH_END};
      default: u = '{ALU_ADD, SRC_SHR, 5'd6, NXT_HASH_END};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/byte_stream_superfast_hash.sv =====
// Byte stream SuperFastHash: top level with register port and output register.
// Uses bssfh_pkg, bssfh_seq and assert_macros.svh.
//
// Input channel in_valid_i / in_stall_o / in_word_i takes one message byte per
// word, with first_byte and last_byte framing; message_length is sampled on
// first_byte. Output channel out_valid_o / out_stall_i / out_word_o carries one
// hash word per message, sent after the last byte, with length_mismatch set
// when the byte count differs from the declared length.
// All steps run on one shared ALU: a byte that closes a 4-byte word starts the
// word mix. A last byte adds up to 4 tail steps, 6 avalanche steps, 32
// restoring modulo steps in data mode (none in string mode or with table_size
// 0) and a handoff state.
// The block stalls its input while busy. A finished hash moves into the output
// register; while the receiver stalls, the next message streams in and waits
// at its handoff cycle only if the output register is still full.
// Reset clears the stream state and output valid, and loads table_size 1024
// and string_mode 0. Registers: table_size at 0x0, string_mode at 0x4.
`default_nettype none
`include "assert_macros.svh"

module byte_stream_superfast_hash (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bssfh_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bssfh_pkg::out_word_t out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  bssfh_pkg::cfg_t      cfg_q, cfg_d;
  bssfh_pkg::seq_stat_t seq_st;
  bssfh_pkg::out_word_t res, out_word_q;
  logic                 out_valid_q, out_valid_d;
  logic                 res_ready, res_load, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[2])
        bssfh_pkg::REG_IDX_TABLE_SIZE:  cfg_d.table_size  = pwdata[30:0];
        bssfh_pkg::REG_IDX_STRING_MODE: cfg_d.string_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bssfh_pkg::REG_IDX_TABLE_SIZE:  prdata = {1'b0, cfg_q.table_size};
      bssfh_pkg::REG_IDX_STRING_MODE: prdata = {31'b0, cfg_q.string_mode};
      default:                        prdata = 32'b0;
    endcase
  end

  bssfh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .res_ready_i (res_ready),
    .stat_o      (seq_st),
    .res_o       (res)
  );

  assign in_stall_o = !seq_st.ready;
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign res_load   = seq_st.res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_size  <= bssfh_pkg::TABLE_SIZE_RST;
      cfg_q.string_mode <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `BSSFH_ASSERT(a_res_held, seq_st.res_valid && !res_ready |=> seq_st.res_valid, "result dropped")
  `BSSFH_ASSERT(a_busy_after_last, in_valid_i && !in_stall_o && in_word_i.last_byte |=> in_stall_o, "not busy")
  `BSSFH_ASSERT(a_fin_stalls, seq_st.res_valid |-> in_stall_o, "input taken during handoff")
  `BSSFH_ASSERT_ALWAYS(a_rst_out, !rst_ni |=> !out_valid_o, "output valid in reset")

endmodule

`default_nettype wire

// ===== rtl/bssfh_alu.sv =====
// Shared 32-bit add / xor / subtract unit of the hash sequencer.
// Uses bssfh_pkg for the operation codes.
`default_nettype none

module bssfh_alu (
  input  bssfh_pkg::alu_op_e op_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic [31:0]        y_o,
  output logic               borrow_o
);

  logic [32:0] diff;

  assign diff = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    borrow_o = 1'b0;
    case (op_i)
      bssfh_pkg::ALU_ADD: y_o = a_i + b_i;
      bssfh_pkg::ALU_XOR: y_o = a_i ^ b_i;
      bssfh_pkg::ALU_SUB: begin
        y_o      = diff[31:0];
        borrow_o = diff[32];
      end
      default: y_o = a_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bssfh_seq.sv =====
// Stream state and microcoded sequencer of the byte stream hash block:
// byte packing, word mix, tail, avalanche and restoring modulo on one ALU.
// Uses bssfh_pkg and bssfh_alu.
`default_nettype none

module bssfh_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bssfh_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  input  bssfh_pkg::in_word_t  in_word_i,
  input  logic                 res_ready_i,
  output bssfh_pkg::seq_stat_t stat_o,
  output bssfh_pkg::out_word_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  pc_q, pc_d;
  logic [31:0] h_q, h_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  phase_q, phase_d;
  logic [30:0] seen_q, seen_d;
  logic [30:0] decl_q, decl_d;
  logic        last_q, last_d;
  logic [30:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;

  bssfh_pkg::uop_t     uop;
  bssfh_pkg::alu_op_e  alu_op;
  logic [31:0]         alu_a, alu_b, alu_y, src_val;
  logic                alu_borrow;
  logic                sgn0, sgn2;

  logic        accept;
  logic [1:0]  phase_eff;
  logic [31:0] word_eff, h_eff;
  logic [30:0] seen_eff, decl_eff;
  logic [31:0] div_a;

  assign uop    = bssfh_pkg::uop_rom(pc_q);
  assign sgn0   = cfg_i.string_mode & word_q[7];
  assign sgn2   = cfg_i.string_mode & word_q[23];
  assign div_a  = {rem_q, h_q[31]};
  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    case (uop.src)
      bssfh_pkg::SRC_SHL:  src_val = h_q << uop.amt;
      bssfh_pkg::SRC_SHR:  src_val = h_q >> uop.amt;
      bssfh_pkg::SRC_LO16: src_val = {16'b0, word_q[15:0]};
      bssfh_pkg::SRC_HI11: src_val = {5'b0, word_q[31:16], 11'b0};
      bssfh_pkg::SRC_B2:   src_val = {{6{sgn2}}, word_q[23:16], 18'b0};
      bssfh_pkg::SRC_B0:   src_val = {{24{sgn0}}, word_q[7:0]};
      default:             src_val = 32'b0;
    endcase
  end

  always_comb begin
    if (state_q == ST_DIV) begin
      alu_op = bssfh_pkg::ALU_SUB;
      alu_a  = div_a;
      alu_b  = {1'b0, cfg_i.table_size};
    end else begin
      alu_op = uop.op;
      alu_a  = h_q;
      alu_b  = src_val;
    end
  end

  bssfh_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .y_o      (alu_y),
    .borrow_o (alu_borrow)
  );

  always_comb begin
    phase_eff = in_word_i.first_byte ? 2'd0 : phase_q;
    word_eff  = in_word_i.first_byte ? 32'd0 : word_q;
    seen_eff  = in_word_i.first_byte ? 31'd0 : seen_q;
    decl_eff  = in_word_i.first_byte ? in_word_i.message_length : decl_q;
    h_eff     = in_word_i.first_byte ? {1'b0, in_word_i.message_length} : h_q;
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    h_d     = h_q;
    word_d  = word_q;
    phase_d = phase_q;
    seen_d  = seen_q;
    decl_d  = decl_q;
    last_d  = last_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          h_d    = h_eff;
          decl_d = decl_eff;
          last_d = in_word_i.last_byte;
          word_d = word_eff | ({24'b0, in_word_i.data_byte} << {phase_eff, 3'b000});
          seen_d = (seen_eff == '1) ? seen_eff : seen_eff + 31'd1;
          if (phase_eff == 2'd3) begin
            phase_d = 2'd0;
            pc_d    = bssfh_pkg::PC_MIX;
            state_d = ST_RUN;
          end else begin
            phase_d = phase_eff + 2'd1;
            if (in_word_i.last_byte) begin
              state_d = ST_RUN;
              case (phase_eff)
                2'd0:    pc_d = bssfh_pkg::PC_TAIL1;
                2'd1:    pc_d = bssfh_pkg::PC_TAIL2;
                default: pc_d = bssfh_pkg::PC_TAIL3;
              endcase
            end
          end
        end
      end
      ST_RUN: begin
        h_d  = alu_y;
        pc_d = pc_q + 5'd1;
        case (uop.nxt)
          bssfh_pkg::NXT_MIX_END: begin
            word_d = 32'd0;
            if (last_q) begin
              pc_d = bssfh_pkg::PC_AVAL;
            end else begin
              state_d = ST_IDLE;
            end
          end
          bssfh_pkg::NXT_AVAL: pc_d = bssfh_pkg::PC_AVAL;
          bssfh_pkg::NXT_HASH_END: begin
            rem_d = 31'd0;
            cnt_d = 5'd0;
            if (!cfg_i.string_mode && (cfg_i.table_size != 31'd0)) begin
              state_d = ST_DIV;
            end else begin
              state_d = ST_FIN;
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        rem_d = alu_borrow ? div_a[30:0] : alu_y[30:0];
        h_d   = {h_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == '1) begin
          h_d     = {1'b0, rem_d};
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          h_d     = 32'd0;
          word_d  = 32'd0;
          phase_d = 2'd0;
          seen_d  = 31'd0;
          decl_d  = 31'd0;
          last_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= 5'd0;
      h_q     <= 32'd0;
      word_q  <= 32'd0;
      phase_q <= 2'd0;
      seen_q  <= 31'd0;
      decl_q  <= 31'd0;
      last_q  <= 1'b0;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      h_q     <= h_d;
      word_q  <= word_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
      decl_q  <= decl_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign stat_o.ready     = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_FIN);
  assign res_o.digest          = h_q;
  assign res_o.length_mismatch = (seen_q != decl_q);

endmodule

`default_nettype wire

// ===== tb/byte_stream_superfast_hash_tb.sv =====
// Self-checking testbench for byte_stream_superfast_hash: streams framed messages, predicts
// each hash word and compares it with the block output under random idling and stalls.
// Depends on bssfh_pkg and the byte_stream_superfast_hash RTL.
`timescale 1ns / 1ps

module byte_stream_superfast_hash_tb;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  bssfh_pkg::in_word_t  in_word = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  bssfh_pkg::out_word_t out_word_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  byte_stream_superfast_hash uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [30:0] cfg_table_size = bssfh_pkg::TABLE_SIZE_RST;
  logic        cfg_string_mode = 1'b0;
  logic [31:0] acc_hash = '0;
  logic [31:0] held_bytes = '0;
  logic [1:0]  held_count = '0;
  logic [30:0] byte_count = '0;
  logic [30:0] length_decl = '0;

  bssfh_pkg::in_word_t  byte_queue[$];
  bssfh_pkg::out_word_t expected_hashes[$];
  bssfh_pkg::out_word_t exp_word;
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          hash_errors = 0;
  bit          word_taken = 1'b0;
  bit          idle_en = 1'b1;
  bit          hold_off_req = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;

  function automatic logic [31:0] widen_tail_byte(input logic [7:0] b);
    if (cfg_string_mode && b[7]) return {24'hFFFFFF, b};
    return {24'd0, b};
  endfunction

  task automatic predict_byte(input bssfh_pkg::in_word_t w);
    logic [31:0]          h;
    logic [2:0]           cnt;
    bssfh_pkg::out_word_t res;
    if (w.first_byte) begin
      acc_hash = {1'b0, w.message_length};
      held_bytes = '0;
      held_count = '0;
      byte_count = '0;
      length_decl = w.message_length;
    end
    held_bytes = held_bytes | ({24'd0, w.data_byte} << (8 * held_count));
    cnt = {1'b0, held_count} + 3'd1;
    if (byte_count != 31'h7FFFFFFF) byte_count = byte_count + 31'd1;
    if (cnt == 3'd4) begin
      h = acc_hash + {16'd0, held_bytes[15:0]};
      h = (h << 16) ^ (({16'd0, held_bytes[31:16]} << 11) ^ h);
      h = h + (h >> 11);
      acc_hash = h;
      held_bytes = '0;
      held_count = '0;
      cnt = 3'd0;
    end else begin
      held_bytes[31:24] = 8'd0;
      held_count = cnt[1:0];
    end
    if (w.last_byte) begin
      h = acc_hash;
      case (cnt)
        3'd3: begin
          h = h + {16'd0, held_bytes[15:0]};
          h = h ^ (h << 16);
          h = h ^ (widen_tail_byte(held_bytes[23:16]) << 18);
          h = h + (h >> 11);
        end
        3'd2: begin
          h = h + {16'd0, held_bytes[15:0]};
          h = h ^ (h << 11);
          h = h + (h >> 17);
        end
        3'd1: begin
          h = h + widen_tail_byte(held_bytes[7:0]);
          h = h ^ (h << 10);
          h = h + (h >> 1);
        end
        default: ;
      endcase
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      if (!cfg_string_mode && cfg_table_size != 31'd0) h = h % {1'b0, cfg_table_size};
      res.digest = h;
      res.length_mismatch = (byte_count != length_decl);
      expected_hashes.push_back(res);
      acc_hash = '0;
      held_bytes = '0;
      held_count = '0;
      byte_count = '0;
      length_decl = '0;
    end
  endtask

  // sample at the rising edge: input acceptance and output check
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o) begin
      predict_byte(in_word);
      void'(byte_queue.pop_front());
      bytes_taken++;
      word_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        hash_errors++;
        if (hash_errors <= 10)
          $display("ERROR: unexpected hash word: hash %h mismatch %b",
                   out_word_o.digest, out_word_o.length_mismatch);
      end else begin
        exp_word = expected_hashes.pop_front();
        if (out_word_o.digest !== exp_word.digest ||
            out_word_o.length_mismatch !== exp_word.length_mismatch) begin
          hash_errors++;
          if (hash_errors <= 10)
            $display("ERROR: hash expected %h/%b, got %h/%b",
                     exp_word.digest, exp_word.length_mismatch,
                     out_word_o.digest, out_word_o.length_mismatch);
        end
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (!in_valid || word_taken) begin
      if (word_taken && idle_en && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_word <= byte_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // hash word receiver
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_config(input logic [30:0] ts, input logic mode);
    apb_write({bssfh_pkg::REG_IDX_TABLE_SIZE, 2'b00}, {1'($urandom), ts});
    apb_write({bssfh_pkg::REG_IDX_STRING_MODE, 2'b00}, {31'($urandom), mode});
    cfg_table_size = ts;
    cfg_string_mode = mode;
  endtask

  task automatic queue_word(input bit first, input logic [30:0] len, input logic [7:0] b,
                            input bit last);
    bssfh_pkg::in_word_t w;
    w.first_byte = first;
    w.message_length = len;
    w.data_byte = b;
    w.last_byte = last;
    byte_queue.push_back(w);
    bytes_queued++;
  endtask

  // wait for every byte and hash word, then let a trailing word mix finish
  task automatic drain_block;
    while (bytes_taken != bytes_queued || expected_hashes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic queue_message(input int len, input logic [30:0] decl, input bit closed);
    for (int i = 0; i < len; i++)
      queue_word(i == 0, (i == 0) ? decl : 31'($urandom), 8'($urandom),
                 closed && (i == len - 1));
  endtask

  task automatic queue_random_bytes(input int count);
    int          len;
    int          added;
    logic [30:0] decl;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_word(1'($urandom), 31'($urandom), 8'($urandom), 1'($urandom));
        added++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
        case ($urandom_range(0, 11))
          0: decl = 31'($urandom);
          1: decl = 31'(len + 1);
          2: decl = 31'(len - 1);
          3: decl = 31'd0;
          default: decl = 31'(len);
        endcase
        queue_message(len, decl, $urandom_range(0, 9) != 0);
        added += len;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bytes with no message started, right after reset
    queue_word(1'b0, 31'($urandom), 8'h5A, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h00, 1'b1);
    queue_word(1'b1, 31'd1, 8'hFF, 1'b1);
    queue_word(1'b1, 31'd2, 8'h00, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h80, 1'b1);
    queue_word(1'b1, 31'd3, 8'hFF, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'hFF, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'hFF, 1'b1);
    queue_word(1'b1, 31'd4, 8'h12, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h34, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h56, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h78, 1'b1);
    // tail follows received bytes, not the declared 7
    queue_message(5, 31'd7, 1'b1);
    queue_word(1'b1, 31'h7FFFFFFF, 8'hA5, 1'b1);
    queue_word(1'b1, 31'd0, 8'h01, 1'b1);
    queue_word(1'b0, 31'h7FFFFFFF, 8'h33, 1'b1);
    // restart in mid message
    queue_word(1'b1, 31'd6, 8'h11, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h22, 1'b0);
    queue_word(1'b1, 31'd2, 8'h44, 1'b0);
    queue_word(1'b0, 31'($urandom), 8'h55, 1'b1);
    drain_block();

    write_config(31'h7FFFFFFF, 1'b1);
    queue_random_bytes(80);
    drain_block();
    write_config(31'd0, 1'b0);
    queue_random_bytes(60);
    drain_block();
    write_config(31'd1, 1'b0);
    queue_random_bytes(50);
    drain_block();
    write_config(31'h7FFFFFFF, 1'b0);
    queue_random_bytes(80);
    drain_block();

    // long receiver hold-off while short messages keep coming
    write_config(31'($urandom), 1'b1);
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) queue_message($urandom_range(1, 5), 31'($urandom_range(1, 5)), 1'b1);
    queue_random_bytes(60);
    drain_block();

    write_config(31'($urandom_range(1, 4096)), 1'b0);
    queue_random_bytes(80);
    drain_block();
    write_config(31'($urandom), 1'b1);
    queue_random_bytes(80);
    drain_block();

    idle_en = 1'b0;
    write_config(31'($urandom_range(1, 65535)), 1'b0);
    queue_random_bytes(100);
    drain_block();

    if (hash_errors == 0 && expected_hashes.size() == 0) begin
      $display("byte_stream_superfast_hash verification clean");
    end else begin
      $display("byte_stream_superfast_hash verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("byte_stream_superfast_hash verification failed");
    $finish;
  end

endmodule
